// ===== rtl/dah_pkg.sv =====
`timescale 1ns / 1ps
package dah_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W = ADDR_W + 1;
   localparam int IDX_W = ADDR_W + 4;
   localparam int VAL_W = 32;
   localparam int COUNT_W = 11;
   localparam logic [VAL_W-1:0] TOP_WHEN_EMPTY = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] SIGN_FLIP = 32'h8000_0000;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_POP_EMPTY  = 2'd1,
      ST_PUSH_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic              op;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic signed [31:0] top_value;
      logic [10:0]        count;
      logic               is_empty;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_UP_PLACE,
      S_DN_ROOT_RD,
      S_DN_LAST_RD,
      S_DN_LAST_WAIT,
      S_DN_FIRST,
      S_DN_CH_RD,
      S_DN_CH_CMP,
      S_DN_DECIDE,
      S_DN_PLACE,
      S_TOP_RD,
      S_TOP_WAIT,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // clear popped and status
      logic up_init;     // moving entry = pushed word, pos = count
      logic rd_par;      // read parent of pos
      logic up_swap;     // parent entry moves down to pos, pos = parent
      logic up_place;    // moving entry lands at pos, count++
      logic rd_last;     // read last entry
      logic dn_pop;      // capture root as popped, count--
      logic dn_last;     // moving entry = last entry, pos = 0
      logic dn_first;    // set up the child scan of pos
      logic rd_ch;       // read child idx
      logic cmp_ch;      // compare child with best, advance idx
      logic dn_swap;     // best child moves up to pos, pos = best
      logic dn_place;    // moving entry lands at pos
      logic cap_top;     // capture root as top
      logic fail_pop;
      logic fail_push;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic up_greater;  // moving entry greater than parent
      logic par_zero;    // parent of pos is the root
      logic no_child;    // first child >= count
      logic ch_more;     // another child left after this one
      logic dn_less;     // moving entry less than best child
   } sts_type;

endpackage

// ===== rtl/dah_ram.sv =====
`timescale 1ns / 1ps
module dah_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/dah_datapath.sv =====
`timescale 1ns / 1ps
module dah_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       arity_log2,
   input  logic [31:0]      req_value,
   input  dah_pkg::ctl_type ctl,
   output dah_pkg::sts_type sts,
   output dah_pkg::rsp_type rsp_word
);
   import dah_pkg::*;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;   // child index, may run past count
   logic [3:0]        left_ff, left_in; // children still to read
   logic [VAL_W-1:0]  val_ff, val_in;   // moving entry
   logic [VAL_W-1:0]  bval_ff, bval_in;
   logic [VAL_W-1:0]  popped_ff, popped_in;
   logic [VAL_W-1:0]  top_ff, top_in;
   logic [1:0]        status_ff, status_in;

   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr, parent;
   logic [VAL_W-1:0]  wr_data, rd_data;
   logic [1:0]        shamt;
   logic [3:0]        arity_n;
   logic [IDX_W-1:0]  first, idx_nx;
   logic [CNT_W-1:0]  last_idx;
   logic              take_ch;

   dah_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(pos_ff),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign shamt    = (arity_log2 == 2'd0) ? 2'd1 : arity_log2;
   assign arity_n  = 4'd1 << shamt;
   assign parent   = (pos_ff - ADDR_W'(1)) >> shamt;
   assign first    = ({4'd0, pos_ff} << shamt) + IDX_W'(1);
   assign idx_nx   = idx_ff + IDX_W'(1);
   assign last_idx = count_ff - CNT_W'(1);
   assign take_ch  = (left_ff == arity_n) ||
                     ((rd_data ^ SIGN_FLIP) > (bval_ff ^ SIGN_FLIP));

   // the moving entry stays in val_ff; only displaced entries are written
   // until it lands
   assign wr_en   = ctl.up_swap | ctl.dn_swap | ctl.up_place | ctl.dn_place;
   assign wr_data = ctl.up_swap ? rd_data : (ctl.dn_swap ? bval_ff : val_ff);

   // address 0 when nothing else reads
   always_comb begin
      rd_addr = '0;
      if (ctl.rd_par) begin
         rd_addr = parent;
      end else if (ctl.rd_last) begin
         rd_addr = last_idx[ADDR_W-1:0];
      end else if (ctl.rd_ch) begin
         rd_addr = idx_ff[ADDR_W-1:0];
      end
   end

   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      best_in   = best_ff;
      idx_in    = idx_ff;
      left_in   = left_ff;
      val_in    = val_ff;
      bval_in   = bval_ff;
      popped_in = popped_ff;
      top_in    = top_ff;
      status_in = status_ff;
      if (ctl.load) begin
         popped_in = '0;
         status_in = ST_OK;
      end
      if (ctl.up_init) begin
         pos_in = count_ff[ADDR_W-1:0];
         val_in = req_value;
      end
      if (ctl.up_swap) begin
         pos_in = parent;
      end
      if (ctl.up_place) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (ctl.dn_pop) begin
         popped_in = rd_data;
         count_in  = last_idx;
      end
      if (ctl.dn_last) begin
         val_in = rd_data;
         pos_in = '0;
      end
      if (ctl.dn_first) begin
         idx_in  = first;
         left_in = arity_n;
      end
      if (ctl.cmp_ch) begin
         if (take_ch) begin
            bval_in = rd_data;
            best_in = idx_ff[ADDR_W-1:0];
         end
         idx_in  = idx_nx;
         left_in = left_ff - 4'd1;
      end
      if (ctl.dn_swap) begin
         pos_in = best_ff;
      end
      if (ctl.cap_top) begin
         top_in = (count_ff == '0) ? TOP_WHEN_EMPTY : rd_data;
      end
      if (ctl.fail_pop) begin
         status_in = ST_POP_EMPTY;
      end
      if (ctl.fail_push) begin
         status_in = ST_PUSH_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         status_ff <= ST_OK;
      end else begin
         count_ff  <= count_in;
         status_ff <= status_in;
      end
      pos_ff    <= pos_in;
      best_ff   <= best_in;
      idx_ff    <= idx_in;
      left_ff   <= left_in;
      val_ff    <= val_in;
      bval_ff   <= bval_in;
      popped_ff <= popped_in;
      top_ff    <= top_in;
   end

   assign sts.full       = (count_ff >= CNT_W'(CAPACITY));
   assign sts.empty      = (count_ff == '0);
   assign sts.up_greater = (val_ff ^ SIGN_FLIP) > (rd_data ^ SIGN_FLIP);
   assign sts.par_zero   = (parent == '0);
   assign sts.no_child   = (first >= IDX_W'(count_ff));
   assign sts.ch_more    = (left_ff != 4'd1) && (idx_nx < IDX_W'(count_ff));
   assign sts.dn_less    = (val_ff ^ SIGN_FLIP) < (bval_ff ^ SIGN_FLIP);

   assign rsp_word.popped_value = popped_ff;
   assign rsp_word.top_value    = top_ff;
   assign rsp_word.count        = COUNT_W'(count_ff);
   assign rsp_word.is_empty     = (count_ff == '0);
   assign rsp_word.status       = status_ff;
endmodule

// ===== rtl/dah_ctrl.sv =====
`timescale 1ns / 1ps
module dah_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  dah_pkg::sts_type sts,
   input  logic             req_op,
   output dah_pkg::ctl_type ctl,
   output logic             busy,
   output logic             done
);
   import dah_pkg::*;

   state_type state_ff, state_in;
   logic      is_push_now;

   assign is_push_now = (req_op == OP_PUSH);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (is_push_now) begin
                  if (sts.full) begin
                     state_in = S_TOP_RD;
                  end else begin
                     state_in = sts.empty ? S_UP_PLACE : S_UP_RD;
                  end
               end else begin
                  state_in = sts.empty ? S_TOP_RD : S_DN_ROOT_RD;
               end
            end
         end
         S_UP_RD:        state_in = S_UP_CMP;
         S_UP_CMP: begin
            if (sts.up_greater && !sts.par_zero) begin
               state_in = S_UP_RD;
            end else begin
               state_in = S_UP_PLACE;
            end
         end
         S_UP_PLACE:     state_in = S_TOP_RD;
         S_DN_ROOT_RD:   state_in = S_DN_LAST_RD;
         S_DN_LAST_RD:   state_in = S_DN_LAST_WAIT;
         S_DN_LAST_WAIT: state_in = S_DN_FIRST;
         S_DN_FIRST:     state_in = sts.no_child ? S_DN_PLACE : S_DN_CH_RD;
         S_DN_CH_RD:     state_in = S_DN_CH_CMP;
         S_DN_CH_CMP:    state_in = sts.ch_more ? S_DN_CH_RD : S_DN_DECIDE;
         S_DN_DECIDE:    state_in = sts.dn_less ? S_DN_FIRST : S_DN_PLACE;
         S_DN_PLACE:     state_in = S_TOP_RD;
         S_TOP_RD:       state_in = S_TOP_WAIT;
         S_TOP_WAIT:     state_in = S_DONE;
         S_DONE:         state_in = S_IDLE;
         default:        state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl  = '0;
      busy = (state_ff != S_IDLE);
      done = (state_ff == S_DONE);
      unique case (state_ff)
         S_IDLE: begin
            ctl.load      = start;
            ctl.up_init   = start && is_push_now && !sts.full;
            ctl.fail_push = start && is_push_now && sts.full;
            ctl.fail_pop  = start && !is_push_now && sts.empty;
         end
         S_UP_RD:        ctl.rd_par = 1'b1;
         S_UP_CMP:       ctl.up_swap = sts.up_greater;
         S_UP_PLACE:     ctl.up_place = 1'b1;
         S_DN_ROOT_RD:   ;
         S_DN_LAST_RD: begin
            ctl.rd_last = 1'b1;
            ctl.dn_pop  = 1'b1;
         end
         S_DN_LAST_WAIT: ctl.dn_last = 1'b1;
         S_DN_FIRST:     ctl.dn_first = 1'b1;
         S_DN_CH_RD:     ctl.rd_ch = 1'b1;
         S_DN_CH_CMP:    ctl.cmp_ch = 1'b1;
         S_DN_DECIDE:    ctl.dn_swap = sts.dn_less;
         S_DN_PLACE:     ctl.dn_place = 1'b1;
         S_TOP_RD:       ;
         S_TOP_WAIT:     ctl.cap_top = 1'b1;
         S_DONE:         ;
         default:        ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== rtl/d_ary_max_heap.sv =====
`timescale 1ns / 1ps
// channel  | ports                          | word taken when
// request  | start, busy, req_word          | start & !busy
// response | rsp_valid, rsp_word            | rsp_valid, one cycle
// csr      | csr_valid, csr_ready, csr_data | csr_valid & csr_ready, idle only
// after a request is taken, a push reads and compares one parent after
// another until the entry lands; a pop reads the root and the last entry,
// then reads and compares the children of each level; a dropped push or
// ignored pop only reads the top. the single ram read port sets the pace;
// the worst case is an eight-ary pop. busy holds through the strobe cycle,
// the next request is taken in the cycle after it. reset clears count,
// status and arity, not the store. the result strobe cannot be stalled.
module d_ary_max_heap (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dah_pkg::req_type req_word,
   output logic             rsp_valid,
   output dah_pkg::rsp_type rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_data
);
   import dah_pkg::*;

   logic [1:0] arity_ff;
   ctl_type    ctl;
   sts_type    sts;

   assign csr_ready = !busy && !start;

   always_ff @(posedge clock) begin
      if (reset) begin
         arity_ff <= 2'd1;
      end else if (csr_valid && csr_ready) begin
         arity_ff <= csr_data;
      end
   end

   dah_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .req_op(req_word.op),
      .ctl   (ctl),
      .busy  (busy),
      .done  (rsp_valid)
   );

   dah_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .arity_log2(arity_ff),
      .req_value (req_word.value),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTHESIS
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside busy");
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.is_empty |-> rsp_word.top_value == 32'sh7FFF_FFFF)
      else $error("empty top wrong");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double strobe");
`endif
endmodule

// ===== test/tb_d_ary_max_heap.sv =====
`timescale 1ns / 1ps
module tb_d_ary_max_heap;
   import dah_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_word = '0;
   logic       rsp_valid;
   rsp_type    rsp_word;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_data = 2'd1;

   // model of the heap
   logic [31:0] heap_mem [CAPACITY];
   int unsigned heap_count;
   logic [1:0]  arity_cfg;

   // expected words in order of acceptance
   rsp_type exp_mem [4096];
   int      exp_wr = 0;
   int      exp_rd = 0;
   int      fail_count = 0;
   int      idle_pct = 0;

   d_ary_max_heap u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic heap_gt(logic [31:0] a, logic [31:0] b);
      return $signed(a) > $signed(b);
   endfunction

   function automatic rsp_type heap_apply(req_type w);
      rsp_type     r;
      int unsigned d, pos, par, first, best, c, last;
      logic [31:0] t;
      logic        done;
      r = '0;
      d = 1 << ((arity_cfg == 2'd0) ? 1 : arity_cfg);
      if (w.op == OP_PUSH) begin
         if (heap_count >= CAPACITY) begin
            r.status = ST_PUSH_FULL;
         end else begin
            heap_mem[heap_count] = w.value;
            pos = heap_count;
            done = 1'b0;
            while (pos > 0 && !done) begin
               par = (pos - 1) / d;
               if (heap_gt(heap_mem[pos], heap_mem[par])) begin
                  t = heap_mem[pos]; heap_mem[pos] = heap_mem[par]; heap_mem[par] = t;
                  pos = par;
               end else begin
                  done = 1'b1;
               end
            end
            heap_count++;
         end
      end else begin
         if (heap_count == 0) begin
            r.status = ST_POP_EMPTY;
         end else begin
            last = heap_count - 1;
            r.popped_value = heap_mem[0];
            heap_mem[0] = heap_mem[last];
            heap_count = last;
            pos = 0;
            done = 1'b0;
            while (!done) begin
               first = d * pos + 1;
               if (first >= heap_count) begin
                  done = 1'b1;
               end else begin
                  best = first;
                  for (c = first + 1; c < first + d && c < heap_count; c++)
                     if (heap_gt(heap_mem[c], heap_mem[best])) best = c;
                  if (!heap_gt(heap_mem[best], heap_mem[pos])) begin
                     done = 1'b1;
                  end else begin
                     t = heap_mem[pos]; heap_mem[pos] = heap_mem[best]; heap_mem[best] = t;
                     pos = best;
                  end
               end
            end
         end
      end
      r.top_value = (heap_count == 0) ? TOP_WHEN_EMPTY : heap_mem[0];
      r.count = heap_count[10:0];
      r.is_empty = (heap_count == 0);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic exp_add(rsp_type r);
      exp_mem[exp_wr & 4095] = r;
      exp_wr++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (exp_rd == exp_wr) begin
            report_mismatch("unexpected word", rsp_word.top_value, 32'd0);
         end else begin
            want = exp_mem[exp_rd & 4095];
            exp_rd++;
            if (rsp_word.popped_value !== want.popped_value)
               report_mismatch("popped_value", rsp_word.popped_value, want.popped_value);
            if (rsp_word.top_value !== want.top_value)
               report_mismatch("top_value", rsp_word.top_value, want.top_value);
            if (rsp_word.count !== want.count)
               report_mismatch("count", 32'(rsp_word.count), 32'(want.count));
            if (rsp_word.is_empty !== want.is_empty)
               report_mismatch("is_empty", 32'(rsp_word.is_empty), 32'(want.is_empty));
            if (rsp_word.status !== want.status)
               report_mismatch("status", 32'(rsp_word.status), 32'(want.status));
         end
      end
   end

   // start stays high until the word is taken; it drops only on idle or drain
   task automatic send_op(op_type op, logic [31:0] val);
      req_type w;
      w.op = op;
      w.value = val;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_word <= {1'($urandom), $urandom};
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      exp_add(heap_apply(w));
   endtask

   task automatic drain;
      start <= 1'b0;
      while (exp_rd != exp_wr) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_arity(logic [1:0] a);
      csr_valid <= 1'b1;
      csr_data <= a;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      arity_cfg = a;
   endtask

   function automatic logic [31:0] rand_value();
      unique case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(7);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed;
      send_op(OP_POP, 32'h0);           // pop on empty heap
      send_op(OP_PUSH, 32'h8000_0000);
      send_op(OP_PUSH, 32'h7FFF_FFFF);
      send_op(OP_PUSH, 32'h0);
      send_op(OP_PUSH, 32'hFFFF_FFFF);
      send_op(OP_PUSH, 32'h7FFF_FFFF);  // equal keys
      send_op(OP_PUSH, 32'h0000_0001);
      for (int i = 0; i < 7; i++) send_op(OP_POP, $urandom);
      send_op(OP_POP, 32'hFFFF_FFFF);
      drain();
      write_arity(2'd0);                // zero arity acts as binary
      for (int i = 0; i < 5; i++) send_op(OP_PUSH, rand_value());
      drain();
      write_arity(2'd3);                // changed while holding entries
      for (int i = 0; i < 6; i++) send_op(OP_POP, 32'h0);
      drain();
   endtask

   // fill in three idling phases, then push into the full heap
   task automatic test_full_heap;
      write_arity(2'd3);
      while (heap_count < CAPACITY) begin
         if (heap_count < 340)
            idle_pct = 0;
         else if (heap_count < 680)
            idle_pct = 61;
         else
            idle_pct = 29;
         send_op(OP_PUSH, rand_value());
      end
      idle_pct = 0;
      send_op(OP_PUSH, 32'h7FFF_FFFF);  // dropped
      send_op(OP_PUSH, 32'h1234_5678);
      drain();
   endtask

   task automatic test_random(int pct, int n);
      idle_pct = pct;
      write_arity(2'($urandom_range(3)));
      for (int i = 0; i < n; i++)
         send_op(($urandom_range(99) < 45) ? OP_PUSH : OP_POP, rand_value());
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      arity_cfg = 2'd1;
      heap_count = 0;
      @(posedge clock);
      test_directed();
      test_full_heap();
      test_random(0, 30);
      test_random(61, 30);
      test_random(29, 30);
      if (fail_count == 0 && exp_rd == exp_wr)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
